@@ hw/rtl/life_grid_generation_engine_core_defines.svh @@
// Assertion macros shared by the life grid engine RTL.
`ifndef LIFE_GRID_GENERATION_ENGINE_CORE_DEFINES_SVH
`define LIFE_GRID_GENERATION_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that the consequent holds in the same cycle as the antecedent.
`define LGGE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LGGE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LGGE_ASSERT_IMP(label, ante, cons, msg)
`define LGGE_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

@@ hw/rtl/lgge_pkg.sv @@
// Shared types, constants and helper functions of the life grid engine.
`timescale 1ns / 1ps

package lgge_pkg;

    // Field widths.
    localparam int ROW_W     = 32;
    localparam int ROW_IDX_W = 5;
    localparam int GS_W      = 6;
    localparam int GEN_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    // Default maximum grid depth.
    localparam int LGGE_MAX_SIZE = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GEN_COUNT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [GS_W-1:0]  GRID_SIZE_RST = 6'd8;
    localparam logic [GEN_W-1:0] GEN_COUNT_RST = 16'd1;

    typedef logic [ROW_W-1:0] t_row;

    // Grid size in use: zero counts as one, large values saturate at the cap.
    function automatic logic [GS_W-1:0] f_active_size(input logic [GS_W-1:0] gs,
                                                      input logic [GS_W-1:0] cap);
        logic [GS_W-1:0] n;
        if (gs == '0) begin
            n = 6'd1;
        end else if (gs > cap) begin
            n = cap;
        end else begin
            n = gs;
        end
        return n;
    endfunction

    // Mask with the low n column bits set.
    function automatic t_row f_col_mask(input logic [GS_W-1:0] n);
        logic [ROW_W:0] wide;
        wide = ((ROW_W+1)'(1) << n) - (ROW_W+1)'(1);
        return wide[ROW_W-1:0];
    endfunction

endpackage

@@ hw/rtl/lgge_ram.sv @@
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps

module lgge_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/lgge_row_unit.sv @@
// Row update unit: applies the B3/S23 rule to one row from its neighbor rows.
`timescale 1ns / 1ps

module lgge_row_unit
    import lgge_pkg::*;
(
    input  t_row i_up,
    input  t_row i_mid,
    input  t_row i_dn,
    input  t_row i_mask,
    output t_row o_next
);

    // Per-column neighbor count as three bit planes, counted modulo eight.
    always_comb begin
        t_row planes [8];
        t_row s0;
        t_row s1;
        t_row s2;
        t_row c0;
        t_row c1;
        planes[0] = (i_up << 1) & i_mask;
        planes[1] = i_up;
        planes[2] = i_up >> 1;
        planes[3] = (i_mid << 1) & i_mask;
        planes[4] = i_mid >> 1;
        planes[5] = (i_dn << 1) & i_mask;
        planes[6] = i_dn;
        planes[7] = i_dn >> 1;
        s0 = '0;
        s1 = '0;
        s2 = '0;
        for (int k = 0; k < 8; k++) begin
            c0 = s0 & planes[k];
            s0 = s0 ^ planes[k];
            c1 = s1 & c0;
            s1 = s1 ^ c0;
            s2 = s2 ^ c1;
        end
        // Three neighbors give birth, two keep the current cell.
        o_next = s1 & ~s2 & (s0 | i_mid) & i_mask;
    end

endmodule

@@ hw/rtl/life_grid_generation_engine_core.sv @@
// Top level of the life grid engine: row load, generation sweeps and row output.
//
//  Channel  | Direction | Handshake                       | Payload
//  ---------+-----------+---------------------------------+---------------------------------
//  config   | in        | i_cfg_we                        | i_cfg_index, i_cfg_data
//  row in   | in        | i_in_valid / o_in_stall         | i_row_cells
//  row out  | out       | o_out_valid / i_out_stall       | o_result_cells, o_result_row,
//           |           |                                 | o_last_row
//
// Rows load while the block is idle; the grid memory port takes one write a cycle.
// Each generation is a sweep over the n rows in use through the shared row unit,
// reading one row a cycle from one grid bank and writing the new row into the other bank.
// Each result row is read from memory, then presented and held through any output stall.
// Reset is synchronous and needs no clearing pass; grid contents are not reset.
// The input is stalled from the last row of a grid until its last result row is taken.
`timescale 1ns / 1ps
`include "life_grid_generation_engine_core_defines.svh"

module life_grid_generation_engine_core
    import lgge_pkg::*;
#(
    parameter int MAX_SIZE = LGGE_MAX_SIZE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // Row input channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [ROW_W-1:0]     i_row_cells,
    // Row output channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [ROW_W-1:0]     o_result_cells,
    output logic [ROW_IDX_W-1:0] o_result_row,
    output logic                 o_last_row
);

    localparam int ROW_CAP = (MAX_SIZE < ROW_W) ? MAX_SIZE : ROW_W;
    localparam int A_W     = $clog2(MAX_SIZE);
    localparam int CNT_W   = $clog2(ROW_CAP + 2);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_GEN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [GS_W-1:0]  r_grid_size;
    logic [GEN_W-1:0] r_gen_count;
    logic [GS_W-1:0]  r_rows, n_rows;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [GEN_W-1:0] r_gen, n_gen;
    logic             r_bank, n_bank;
    logic             r_out_valid, n_out_valid;
    t_row             r_up, n_up;
    t_row             r_mid, n_mid;

    logic [GS_W-1:0]  w_n;
    logic [CNT_W-1:0] w_n_cnt;
    t_row             w_mask;
    logic [GS_W-1:0]  w_load_idx;
    logic             w_load_last;
    logic             w_in_acc;
    logic             w_out_acc;
    logic             w_last;
    logic             w_gen_wr;
    logic             w_gen_end;
    t_row             w_q0, w_q1, w_rdata;
    t_row             w_row_in;
    t_row             w_next_row;
    logic             w_we0, w_we1;
    logic [A_W-1:0]   w_waddr, w_raddr;
    t_row             w_wdata;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_SIZE_RST;
            r_gen_count <= GEN_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GRID_SIZE: r_grid_size <= i_cfg_data[GS_W-1:0];
                REG_GEN_COUNT: r_gen_count <= i_cfg_data[GEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Grid geometry and handshake decode.
    assign w_n         = f_active_size(r_grid_size, GS_W'(ROW_CAP));
    assign w_n_cnt     = CNT_W'(w_n);
    assign w_mask      = f_col_mask(w_n);
    assign w_load_idx  = (r_rows > w_n - 6'd1) ? (w_n - 6'd1) : r_rows;
    assign w_load_last = (w_load_idx == w_n - 6'd1);
    assign w_in_acc    = i_in_valid && (r_state == ST_IDLE);
    assign w_out_acc   = r_out_valid && !i_out_stall;
    assign w_last      = (r_cnt == w_n_cnt - CNT_W'(1));
    assign w_gen_wr    = (r_state == ST_GEN) && (r_cnt >= CNT_W'(2));
    assign w_gen_end   = (r_state == ST_GEN) && (r_cnt == w_n_cnt + CNT_W'(1));

    // Row window: the incoming row is valid for sweep steps 1 to n.
    assign w_rdata  = r_bank ? w_q1 : w_q0;
    assign w_row_in = ((r_cnt != '0) && (r_cnt <= w_n_cnt)) ? w_rdata : '0;

    lgge_row_unit u_row_unit (
        .i_up   (r_up),
        .i_mid  (r_mid),
        .i_dn   (w_row_in),
        .i_mask (w_mask),
        .o_next (w_next_row)
    );

    // Grid bank ports: loads write the current bank, sweeps write the other one.
    assign w_waddr = (r_state == ST_IDLE) ? A_W'(w_load_idx) : A_W'(r_cnt - CNT_W'(2));
    assign w_wdata = (r_state == ST_IDLE) ? (i_row_cells & w_mask) : w_next_row;
    assign w_we0   = (w_in_acc && !r_bank) || (w_gen_wr && r_bank);
    assign w_we1   = (w_in_acc && r_bank) || (w_gen_wr && !r_bank);

    always_comb begin
        if ((r_state == ST_GEN) && (r_cnt >= w_n_cnt)) begin
            w_raddr = '0;
        end else begin
            w_raddr = A_W'(r_cnt);
        end
    end

    lgge_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SIZE)
    ) u_grid_bank0 (
        .i_clk   (i_clk),
        .i_we    (w_we0),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_q0)
    );

    lgge_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SIZE)
    ) u_grid_bank1 (
        .i_clk   (i_clk),
        .i_we    (w_we1),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_q1)
    );

    // Sequencer: load rows, sweep generations, then present result rows.
    always_comb begin
        n_state     = r_state;
        n_rows      = r_rows;
        n_cnt       = r_cnt;
        n_gen       = r_gen;
        n_bank      = r_bank;
        n_out_valid = r_out_valid;
        n_up        = r_up;
        n_mid       = r_mid;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    if (w_load_last) begin
                        n_rows  = '0;
                        n_cnt   = '0;
                        n_gen   = '0;
                        n_up    = '0;
                        n_mid   = '0;
                        n_state = (r_gen_count == '0) ? ST_OUT : ST_GEN;
                    end else begin
                        n_rows = w_load_idx + 6'd1;
                    end
                end
            end
            ST_GEN: begin
                n_up  = r_mid;
                n_mid = w_row_in;
                n_cnt = r_cnt + CNT_W'(1);
                if (w_gen_end) begin
                    n_cnt  = '0;
                    n_up   = '0;
                    n_mid  = '0;
                    n_bank = !r_bank;
                    if (r_gen + 16'd1 == r_gen_count) begin
                        n_gen   = '0;
                        n_state = ST_OUT;
                    end else begin
                        n_gen = r_gen + 16'd1;
                    end
                end
            end
            ST_OUT: begin
                if (!r_out_valid) begin
                    n_out_valid = 1'b1;
                end else if (w_out_acc) begin
                    n_out_valid = 1'b0;
                    if (w_last) begin
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rows      <= '0;
            r_cnt       <= '0;
            r_gen       <= '0;
            r_bank      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rows      <= n_rows;
            r_cnt       <= n_cnt;
            r_gen       <= n_gen;
            r_bank      <= n_bank;
            r_out_valid <= n_out_valid;
        end
    end

    // Row window registers.
    always_ff @(posedge i_clk) begin
        r_up  <= n_up;
        r_mid <= n_mid;
    end

    // Outputs.
    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_result_cells = w_rdata & w_mask;
    assign o_result_row   = ROW_IDX_W'(r_cnt);
    assign o_last_row     = w_last;

    // Assertions.
    `LGGE_ASSERT_IMP(a_out_valid_in_out, r_out_valid, r_state == ST_OUT, "result outside output phase")
    `LGGE_ASSERT_IMP(a_rows_below_cap, 1'b1, r_rows < GS_W'(ROW_CAP), "row count past grid limit")
    `LGGE_ASSERT_IMP(a_gen_in_range, r_state == ST_GEN, r_gen < r_gen_count, "generation count overrun")
    `LGGE_ASSERT_NXT(a_grid_done_busy, w_in_acc && w_load_last, r_state != ST_IDLE, "grid not processed")
    `LGGE_ASSERT_NXT(a_last_row_idle, w_out_acc && w_last, r_state == ST_IDLE && !r_out_valid, "no idle after last row")

endmodule

@@ verif/tb_life_grid_generation_engine_core.sv @@
// Self-checking testbench for the life grid engine core with a built-in B3/S23 predictor.
`timescale 1ns / 1ps

module tb_life_grid_generation_engine_core;
    import lgge_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int TARGET_ROWS   = 330;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_AFTER    = 30;

    // One emitted grid row as the block presents it.
    typedef struct packed {
        t_row                 cells;
        logic [ROW_IDX_W-1:0] index;
        logic                 last;
    } t_grid_row;

    // Clock, reset and the block's ports.
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_SIZE;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    t_row                 row_cells = '0;
    logic                 out_stall = 1'b0;
    logic                 in_stall;
    logic                 out_valid;
    t_row                 result_cells;
    logic [ROW_IDX_W-1:0] result_row;
    logic                 last_row;

    // Predictor state: its own copy of the grid, load position and settings.
    t_row             life_cells [0:LGGE_MAX_SIZE-1];
    int               rows_in_load = 0;
    logic [GS_W-1:0]  size_setting = GRID_SIZE_RST;
    logic [GEN_W-1:0] gen_setting  = GEN_COUNT_RST;

    // Rows waiting to be sent and result rows waiting to arrive.
    t_row      row_queue [$];
    t_grid_row expected_rows [$];

    int rows_sent    = 0;
    int rows_checked = 0;
    int mismatches   = 0;

    // Sender burst shaping and receiver stall shaping.
    int burst_left   = 0;
    int gap_left     = 0;
    int stall_pct    = 0;
    int pattern_left = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;

    life_grid_generation_engine_core u_top (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_row_cells    (row_cells),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_result_cells (result_cells),
        .o_result_row   (result_row),
        .o_last_row     (last_row)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Rows in use: zero means a single row, anything past the cap saturates.
    function automatic int grid_rows_in_use();
        if (size_setting == '0) begin
            return 1;
        end
        if (size_setting > LGGE_MAX_SIZE) begin
            return LGGE_MAX_SIZE;
        end
        return int'(size_setting);
    endfunction

    function automatic t_row columns_in_use(input int n);
        return (n >= ROW_W) ? {ROW_W{1'b1}} : ((t_row'(1) << n) - t_row'(1));
    endfunction

    // Advances the stored grid by the configured number of generations.
    // Neighbors come straight from the stored rows, so a column just past the
    // edge only counts when a stale bit from an earlier, wider load is there.
    task automatic advance_life(input int n);
        t_row fresh [0:LGGE_MAX_SIZE-1];
        int   live;
        bit   settled;
        for (int g = 0; g < int'(gen_setting); g++) begin
            settled = 1'b1;
            for (int r = 0; r < n; r++) begin
                fresh[r] = '0;
                for (int c = 0; c < n; c++) begin
                    live = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < n &&
                                c + dc >= 0 && c + dc < ROW_W) begin
                                live += life_cells[r + dr][c + dc];
                            end
                        end
                    end
                    if (live == 3 || (live == 2 && life_cells[r][c])) begin
                        fresh[r][c] = 1'b1;
                    end
                end
            end
            for (int r = 0; r < n; r++) begin
                if (fresh[r] != life_cells[r]) begin
                    settled = 1'b0;
                end
                life_cells[r] = fresh[r];
            end
            // A grid that no longer changes stays the same for all later generations.
            if (settled) begin
                break;
            end
        end
    endtask

    // Stores one accepted row; the row that completes a grid yields the whole result.
    task automatic take_row(input t_row cells);
        int   n;
        int   slot;
        t_row mask;
        n    = grid_rows_in_use();
        mask = columns_in_use(n);
        slot = (rows_in_load > n - 1) ? n - 1 : rows_in_load;
        life_cells[slot] = cells & mask;
        if (slot + 1 < n) begin
            rows_in_load = slot + 1;
            return;
        end
        rows_in_load = 0;
        advance_life(n);
        for (int r = 0; r < n; r++) begin
            expected_rows.push_back(t_grid_row'{life_cells[r] & mask, ROW_IDX_W'(r),
                                                r == n - 1});
        end
    endtask

    function automatic t_row random_row();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            return $urandom;
        end
        if (pick < 75) begin
            return $urandom & $urandom;
        end
        if (pick < 85) begin
            return $urandom & $urandom & $urandom;
        end
        if (pick < 90) begin
            return {ROW_W{1'b1}};
        end
        if (pick < 95) begin
            return '0;
        end
        return t_row'(1) << $urandom_range(0, ROW_W - 1);
    endfunction

    task automatic push_row(input t_row cells);
        row_queue.push_back(cells);
        rows_sent++;
    endtask

    task automatic push_grid(input int n);
        for (int i = 0; i < n; i++) begin
            push_row(random_row());
        end
    endtask

    // Waits until every row is sent and every result has arrived, then lets the block settle.
    task automatic wait_until_idle();
        while (row_queue.size() != 0 || expected_rows.size() != 0 || in_valid) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] reg_index,
                                  input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= reg_index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (reg_index == REG_GRID_SIZE) begin
            size_setting = value[GS_W-1:0];
        end else begin
            gen_setting = value[GEN_W-1:0];
        end
    endtask

    task automatic configure(input logic [CFG_W-1:0] size_value,
                             input logic [CFG_W-1:0] gen_value);
        wait_until_idle();
        write_register(REG_GRID_SIZE, size_value);
        write_register(REG_GEN_COUNT, gen_value);
    endtask

    // Row driver: offers queued rows in bursts and holds a stalled transaction steady.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid   <= 1'b0;
            burst_left = $urandom_range(1, 40);
            gap_left   = 0;
        end else begin
            if (in_valid && !in_stall) begin
                take_row(row_cells);
                void'(row_queue.pop_front());
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = $urandom_range(1, 12);
                end
            end
            if (in_valid && in_stall) begin
                // Stalled transaction: valid and payload stay as they are.
            end else if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (row_queue.size() > 0) begin
                in_valid  <= 1'b1;
                row_cells <= row_queue[0];
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with one long hold-off while rows are still waiting.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
                pattern_left = $urandom_range(16, 128);
            end else begin
                pattern_left--;
            end
            if (!hold_done && rows_checked >= HOLD_AFTER && row_queue.size() > 0) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Result monitor: each accepted row is checked against the oldest expected row.
    always @(posedge clk) begin
        t_grid_row want;
        if (rst_n && out_valid && !out_stall) begin
            rows_checked++;
            if (expected_rows.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result row %0d, cells %h",
                         $time, result_row, result_cells);
            end else begin
                want = expected_rows.pop_front();
                if (result_cells !== want.cells) begin
                    mismatches++;
                    $display("%0t: result_cells on row %0d: expected %h, actual %h",
                             $time, want.index, want.cells, result_cells);
                end
                if (result_row !== want.index) begin
                    mismatches++;
                    $display("%0t: result_row: expected %0d, actual %0d",
                             $time, want.index, result_row);
                end
                if (last_row !== want.last) begin
                    mismatches++;
                    $display("%0t: last_row on row %0d: expected %0b, actual %0b",
                             $time, want.index, want.last, last_row);
                end
            end
        end
    end

    // Stimulus: directed grids first, then random phases of settings and grids.
    initial begin
        int               size_pick;
        int               gs_value;
        int               gens;
        int               n;
        int               partial;
        int               grids;
        int               phase_no;
        logic [CFG_W-1:0] size_data;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: 8 by 8, one generation, with full rows and bits past the edge.
        push_row(32'h0000_0000);
        push_row(32'hFFFF_FFFF);
        push_row(32'h0000_0000);
        push_row(32'h0000_0038);
        push_row(32'h0000_0000);
        push_row(32'h8000_0080);
        push_row(32'h0000_0081);
        push_row(32'hF000_00C1);

        // A size of zero acts as one cell; zero generations return the masked row.
        configure(16'd0, 16'd0);
        push_row(32'hFFFF_FFFF);

        // Vertical blinker on a 3 by 3 grid over two generations.
        configure(16'd3, 16'd2);
        push_row(32'h0000_0002);
        push_row(32'h0000_0002);
        push_row(32'h0000_0002);

        // Largest generation count on a one-cell grid.
        configure(16'd1, 16'hFFFF);
        push_row(32'h0000_0001);

        // Horizontal blinker over an odd number of generations.
        configure(16'd5, 16'd1001);
        push_row(32'h0000_0000);
        push_row(32'h0000_0000);
        push_row(32'h0000_000E);
        push_row(32'h0000_0000);
        push_row(32'h0000_0000);

        // Partial load, then the size drops below the rows already taken.
        configure(16'd6, 16'd0);
        push_row(32'hFFFF_FFFF);
        push_row(32'hFFFF_FFFF);
        push_row(32'hFFFF_FFFF);
        push_row(32'hFFFF_FFFF);
        wait_until_idle();
        write_register(REG_GRID_SIZE, 16'd2);
        write_register(REG_GEN_COUNT, 16'd1);
        push_row(32'h0000_0003);

        // Random phases, mostly small grids; the first two hit the full and saturated sizes.
        phase_no = 0;
        while (rows_sent < TARGET_ROWS) begin
            size_pick = $urandom_range(0, 99);
            if (phase_no == 0) begin
                gs_value = 32;
            end else if (phase_no == 1) begin
                gs_value = 63;
            end else if (size_pick < 60) begin
                gs_value = $urandom_range(1, 8);
            end else if (size_pick < 78) begin
                gs_value = $urandom_range(9, 16);
            end else if (size_pick < 90) begin
                gs_value = $urandom_range(17, 32);
            end else if (size_pick < 95) begin
                gs_value = 0;
            end else begin
                gs_value = $urandom_range(33, 63);
            end

            size_pick = $urandom_range(0, 99);
            if (size_pick < 15) begin
                gens = 0;
            end else if (size_pick < 80) begin
                gens = $urandom_range(1, 4);
            end else if (size_pick < 95 || gs_value > 8) begin
                gens = $urandom_range(5, 20);
            end else begin
                gens = $urandom_range(21, 300);
            end

            // Bits above the size field are sometimes set; the register keeps the low bits.
            size_data = CFG_W'(gs_value);
            if ($urandom_range(0, 4) == 0) begin
                size_data[CFG_W-1:GS_W] = (CFG_W-GS_W)'($urandom);
            end

            if (phase_no < 2 || $urandom_range(0, 3) != 0) begin
                configure(size_data, CFG_W'(gens));
            end
            n = grid_rows_in_use();

            if (n >= 2 && $urandom_range(0, 9) == 0) begin
                // Stop part way through a load and shrink the grid under it.
                partial = $urandom_range(1, n - 1);
                push_grid(partial);
                wait_until_idle();
                write_register(REG_GRID_SIZE, CFG_W'($urandom_range(1, partial)));
                push_row(random_row());
            end else begin
                grids = (n > 16) ? $urandom_range(1, 2) : $urandom_range(1, 4);
                for (int i = 0; i < grids; i++) begin
                    push_grid(n);
                end
            end
            phase_no++;
        end

        wait_until_idle();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog for a block that stops answering.
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/lgge_pkg.sv
hw/rtl/lgge_ram.sv
hw/rtl/lgge_row_unit.sv
hw/rtl/life_grid_generation_engine_core.sv
verif/tb_life_grid_generation_engine_core.sv
